@@ sv/tcw_pkg.sv @@
// Shared constants and types of the text console writer.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;
    localparam int OFFS_W     = 12;
    localparam int CELL_W     = 16;
    localparam int CLR_W      = 4;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_SETPOS = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] BLANK_CLEAR = 16'h0720;

    localparam logic [0:0] REG_FG = 1'b0;
    localparam logic [0:0] REG_BG = 1'b1;

    localparam logic [CLR_W-1:0] FG_RESET = 4'd7;
    localparam logic [CLR_W-1:0] BG_RESET = 4'd0;

endpackage

`default_nettype wire

@@ sv/text_console_writer.sv @@
// Text console writer: cell store, cursor logic and the store sequencer.
//
// Usage: one command transaction enters on the s_ channel (operation in
// s_tuser), one status transaction leaves on the m_ channel per command.
// Colours are set through the cfg_ write port; the user must write them only
// while the block is idle, as the block itself does not enforce this. All
// cell traffic goes through one store with one write and one read port per
// cycle, driven by a small sequencer; s_tready is high only while the
// sequencer is idle, so one command is worked on at a time.
// Carriage return, line feed without scroll, set position and read cell go
// from S_EXEC straight to S_DONE; a printable character or backspace also
// passes S_PUT, which writes the cell. S_DONE fills the output register.
// A row advance past the bottom line scrolls the store: one cell is copied
// per cycle and the new bottom line, COLUMNS cells, is then filled. Clear
// screen sweeps all ROWS*COLUMNS cells.
// After reset the block runs a clearing pass over the store before s_tready
// rises; cfg_ writes are taken during it.
// A command may be accepted while the previous status still waits in the
// output register; a stalled m_ side holds the finished command until the
// output register frees, and the block takes nothing new meanwhile.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // command channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // char_code[7:0], new_col[14:8], new_row[19:15], new_follow[20],
    // cell_index[31:21]
    input  wire logic [31:0] s_tdata,
    // operation[1:0]
    input  wire logic [1:0]  s_tuser,
    // status channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cursor_col[6:0], cursor_row[11:7], cursor_offset[23:12],
    // cursor_update[24], cell_data[40:25], zero[47:41]
    output logic [47:0]      m_tdata,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [3:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_SCROLL,
        S_FILL,
        S_PUT,
        S_CLEAR,
        S_DONE
    } state_t;

    localparam logic [COL_W-1:0]  COLS_C   = COL_W'(COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [OFFS_W-1:0] COLS_O   = OFFS_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_END = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
    localparam logic [10:0]       CNT_LIM  = 11'(CELL_COUNT);

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  cnt_reg, cnt_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               follow_reg, follow_next;
    logic [CLR_W-1:0]   fg_reg, fg_next;
    logic [CLR_W-1:0]   bg_reg, bg_next;
    op_t                op_reg, op_next;
    logic [7:0]         ch_reg, ch_next;
    logic [COL_W-1:0]   ncol_reg, ncol_next;
    logic [ROW_W-1:0]   nrow_reg, nrow_next;
    logic               nfollow_reg, nfollow_next;
    logic [10:0]        cidx_reg, cidx_next;
    logic               put_pend_reg, put_pend_next;
    logic               put_inc_reg, put_inc_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [47:0]        m_tdata_reg, m_tdata_next;

    logic [OFFS_W-1:0]  offset;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;
    logic               out_free;
    logic [CELL_W-1:0]  cell_out;
    logic               upd_out;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [CLR_W-1:0] bg,
        input logic [CLR_W-1:0] fg,
        input logic [7:0]       ch
    );
        return {bg, fg, ch};
    endfunction

    assign offset   = OFFS_W'(row_reg) * COLS_O + OFFS_W'(col_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign ram_raddr = (state_reg == S_SCROLL) ? cnt_reg + COLS_A : cidx_reg[ADDR_W-1:0];

    // store write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = BLANK_CLEAR;
        unique case (state_reg)
            S_INIT, S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_SCROLL: begin
                // the copy lags the read: it writes the cell read in the cycle before
                ram_we    = (cnt_reg != '0);
                ram_waddr = cnt_reg - ADDR_W'(1);
                ram_wdata = ram_rdata;
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = make_cell(bg_reg, fg_reg, CH_SPACE);
            end
            S_PUT: begin
                ram_we    = (offset < OFFS_W'(CELL_COUNT));
                ram_waddr = offset[ADDR_W-1:0];
                ram_wdata = make_cell(bg_reg, fg_reg, put_inc_reg ? ch_reg : CH_SPACE);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        cell_out = '0;
        if (op_reg == OP_READ && cidx_reg < CNT_LIM) begin
            cell_out = ram_rdata;
        end
        upd_out = (op_reg == OP_WRITE || op_reg == OP_CLEAR) ? follow_reg : 1'b0;
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        follow_next   = follow_reg;
        fg_next       = fg_reg;
        bg_next       = bg_reg;
        op_next       = op_reg;
        ch_next       = ch_reg;
        ncol_next     = ncol_reg;
        nrow_next     = nrow_reg;
        nfollow_next  = nfollow_reg;
        cidx_next     = cidx_reg;
        put_pend_next = put_pend_reg;
        put_inc_next  = put_inc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FG: fg_next = cfg_wdata;
                REG_BG: bg_next = cfg_wdata;
                default: fg_next = fg_reg;
            endcase
        end

        unique case (state_reg)
            S_INIT: begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next      = op_t'(s_tuser);
                    ch_next      = s_tdata[7:0];
                    ncol_next    = s_tdata[14:8];
                    nrow_next    = s_tdata[19:15];
                    nfollow_next = s_tdata[20];
                    cidx_next    = s_tdata[31:21];
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                put_pend_next = 1'b0;
                put_inc_next  = 1'b0;
                cnt_next      = '0;
                state_next    = S_DONE;
                unique case (op_reg)
                    OP_WRITE: begin
                        priority if (ch_reg == CH_CR) begin
                            col_next = '0;
                        end else if (ch_reg == CH_LF) begin
                            if (row_reg >= LAST_ROW) begin
                                state_next = S_SCROLL;
                            end else begin
                                row_next = row_reg + ROW_W'(1);
                            end
                        end else if (ch_reg == CH_BS) begin
                            if (col_reg != '0) begin
                                col_next = col_reg - COL_W'(1);
                            end
                            state_next = S_PUT;
                        end else begin
                            put_inc_next = 1'b1;
                            state_next   = S_PUT;
                            if (col_reg >= COLS_C) begin
                                col_next = '0;
                                if (row_reg >= LAST_ROW) begin
                                    put_pend_next = 1'b1;
                                    state_next    = S_SCROLL;
                                end else begin
                                    row_next = row_reg + ROW_W'(1);
                                end
                            end
                        end
                    end
                    OP_CLEAR: begin
                        state_next = S_CLEAR;
                    end
                    OP_SETPOS: begin
                        col_next    = (ncol_reg > COLS_C) ? COLS_C : ncol_reg;
                        row_next    = (nrow_reg > LAST_ROW) ? LAST_ROW : nrow_reg;
                        follow_next = nfollow_reg;
                    end
                    OP_READ: begin
                        // read address is already on the store; data arrives in S_DONE
                        state_next = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_SCROLL: begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == COPY_END) begin
                    cnt_next   = COPY_END;
                    row_next   = LAST_ROW;
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_IDX) begin
                    state_next = put_pend_reg ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                if (put_inc_reg) begin
                    col_next = col_reg + COL_W'(1);
                end
                state_next = S_DONE;
            end
            S_CLEAR: begin
                cnt_next = cnt_reg + ADDR_W'(1);
                if (cnt_reg == LAST_IDX) begin
                    col_next   = '0;
                    row_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, cell_out, upd_out, offset, row_reg, col_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            cnt_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            follow_reg   <= 1'b1;
            fg_reg       <= FG_RESET;
            bg_reg       <= BG_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            follow_reg   <= follow_next;
            fg_reg       <= fg_next;
            bg_reg       <= bg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg       <= op_next;
        ch_reg       <= ch_next;
        ncol_reg     <= ncol_next;
        nrow_reg     <= nrow_next;
        nfollow_reg  <= nfollow_next;
        cidx_reg     <= cidx_next;
        put_pend_reg <= put_pend_next;
        put_inc_reg  <= put_inc_next;
        m_tdata_reg  <= m_tdata_next;
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

`default_nettype wire

@@ sv/tcw_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
